@@ hdl/ilh_pkg.sv @@
package ilh_pkg;

  localparam int unsigned SlotCountDef    = 20;
  localparam int unsigned CaptureDepthDef = 8;

  localparam int unsigned TsW   = 64;
  localparam int unsigned CfgW  = 40;
  localparam int unsigned SlotW = 5;
  localparam int unsigned LatW  = 63;
  localparam int unsigned CntW  = 32;

  localparam int unsigned InTdataW  = 72;
  localparam int unsigned OutTdataW = 104;

  localparam int unsigned InKindBit   = 64;
  localparam int unsigned InSlotLsb   = 65;
  localparam int unsigned OutRecBit   = 0;
  localparam int unsigned OutSlotLsb  = 1;
  localparam int unsigned OutCapBit   = 6;
  localparam int unsigned OutLatLsb   = 7;
  localparam int unsigned OutOvfBit   = 70;
  localparam int unsigned OutCntLsb   = 71;

  localparam logic [CfgW-1:0] PeriodReset = 40'd10000000;
  localparam logic [CfgW-1:0] TraceReset  = 40'd50000000;

  typedef enum logic [1:0] {
    MODE_HRES  = 2'd0,
    MODE_TIMER = 2'd1,
    MODE_READ  = 2'd2,
    MODE_START = 2'd3
  } mode_e;

  typedef enum logic {
    REG_PERIOD = 1'b0,
    REG_TRACE  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic load;
    logic delta;
    logic delta_soft;
    logic stamp;
    logic scan;
    logic soft_arm;
    logic capture;
    logic mem_rd;
    logic mem_wr;
    logic read_out;
    logic emit;
  } ilh_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  scan_ge;
    logic  scan_last;
    logic  pass;
    logic  count;
    logic  soft_path;
    logic  soft_delayed;
    logic  soft_ge;
    logic  out_free;
  } ilh_status_t;

endpackage

@@ hdl/ilh_ctrl.sv @@
module ilh_ctrl
  import ilh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  ilh_status_t status_i,
  output ilh_cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_DELTA = 9'b000000010,
    ST_SCAN  = 9'b000000100,
    ST_EVAL  = 9'b000001000,
    ST_SOFT  = 9'b000010000,
    ST_SCHK  = 9'b000100000,
    ST_READ  = 9'b001000000,
    ST_WRITE = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DELTA;
        end
      end
      ST_DELTA: begin
        cmd_o.delta      = 1'b1;
        cmd_o.delta_soft = (status_i.mode == MODE_TIMER);
        cmd_o.stamp      = 1'b1;
        case (status_i.mode)
          MODE_READ: begin
            cmd_o.mem_rd = 1'b1;
            state_d      = ST_READ;
          end
          MODE_START: state_d = ST_DONE;
          default:    state_d = ST_SCAN;
        endcase
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (!status_i.scan_ge || status_i.scan_last) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.capture = 1'b1;
        if (status_i.pass) begin
          if (status_i.count) begin
            cmd_o.mem_rd = 1'b1;
            state_d      = ST_WRITE;
          end else begin
            state_d = ST_DONE;
          end
        end else if (status_i.mode == MODE_HRES && !status_i.soft_path &&
                     !status_i.soft_delayed) begin
          state_d = ST_SOFT;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SOFT: begin
        cmd_o.delta      = 1'b1;
        cmd_o.delta_soft = 1'b1;
        state_d          = ST_SCHK;
      end
      ST_SCHK: begin
        if (status_i.soft_ge) begin
          cmd_o.soft_arm = 1'b1;
          state_d        = ST_SCAN;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        cmd_o.read_out = 1'b1;
        state_d        = ST_DONE;
      end
      ST_WRITE: begin
        cmd_o.mem_wr = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/ilh_dp.sv @@
module ilh_dp
  import ilh_pkg::*;
#(
  parameter int unsigned NUM_SLOTS     = SlotCountDef,
  parameter int unsigned CAPTURE_DEPTH = CaptureDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_wdata_i,
  input  logic [InTdataW-1:0]  in_data_i,
  input  logic [1:0]           in_user_i,
  input  ilh_cmd_t             cmd_i,
  output ilh_status_t          status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OutTdataW-1:0] out_data_o,
  output logic                 out_user_o
);

  localparam int unsigned Entries = 2 * NUM_SLOTS;
  localparam int unsigned AddrW   = $clog2(Entries);
  localparam int unsigned KW      = $clog2(NUM_SLOTS);
  localparam int unsigned CcW     = $clog2(CAPTURE_DEPTH + 1);

  logic [CfgW-1:0]  period_q, trace_q;
  logic [TsW-1:0]   hard_q, soft_q;
  logic             soft_delayed_q;

  mode_e            mode_q;
  logic [TsW-1:0]   now_q;
  logic             rkind_q;
  logic [SlotW-1:0] rslot_q;

  logic [TsW-1:0]   delta_q, sh_q;
  logic [KW-1:0]    k_q;
  logic [SlotW-1:0] slot_q;
  logic             pass_q, kind_q, count_q;

  logic [CcW-1:0]   cc_q [2];

  logic [CntW-1:0]  mem [Entries];
  logic [Entries-1:0] mem_vld_q;
  logic [CntW-1:0]  rd_q;
  logic             rd_vld_q;
  logic             rd_oob_q;
  logic [AddrW-1:0] addr_q;
  logic [AddrW-1:0] mem_addr;
  logic [CntW-1:0]  rd_eff;

  logic             res_rec_q, res_cap_q, res_kind_q, res_ovf_q;
  logic [SlotW-1:0] res_slot_q;
  logic [LatW-1:0]  res_lat_q;
  logic [CntW-1:0]  res_cnt_q;

  logic                 out_valid_q;
  logic [OutTdataW-1:0] out_data_q;
  logic                 out_user_q;

  logic [CfgW:0]    thr;
  logic [TsW-1:0]   delta_d;
  logic             read_oob;

  assign thr      = {1'b0, trace_q} + {1'b0, period_q};
  assign delta_d  = now_q - (cmd_i.delta_soft ? soft_q : hard_q);
  assign read_oob = ({1'b0, rslot_q} >= (SlotW + 1)'(NUM_SLOTS));
  assign rd_eff   = rd_vld_q ? rd_q : '0;

  always_comb begin
    if (mode_q == MODE_READ) begin
      mem_addr = (rkind_q ? AddrW'(NUM_SLOTS) : '0) + AddrW'(rslot_q);
    end else begin
      mem_addr = (kind_q ? AddrW'(NUM_SLOTS) : '0) + AddrW'(slot_q);
    end
  end

  assign status_o.mode         = mode_q;
  assign status_o.scan_ge      = (sh_q >= {{(TsW - CfgW){1'b0}}, period_q});
  assign status_o.scan_last    = (k_q == KW'(NUM_SLOTS - 1));
  assign status_o.pass         = pass_q;
  assign status_o.count        = count_q;
  assign status_o.soft_path    = kind_q;
  assign status_o.soft_delayed = soft_delayed_q;
  assign status_o.soft_ge      = (delta_q >= {{(TsW - CfgW - 1){1'b0}}, thr});
  assign status_o.out_free     = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q       <= PeriodReset;
      trace_q        <= TraceReset;
      hard_q         <= '0;
      soft_q         <= '0;
      soft_delayed_q <= 1'b0;
      cc_q[0]        <= '0;
      cc_q[1]        <= '0;
      mem_vld_q      <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PERIOD: period_q <= cfg_wdata_i;
          REG_TRACE:  trace_q  <= cfg_wdata_i;
          default:    period_q <= period_q;
        endcase
      end
      if (cmd_i.stamp) begin
        case (mode_q)
          MODE_HRES: hard_q <= now_q;
          MODE_TIMER: begin
            soft_q         <= now_q;
            soft_delayed_q <= 1'b0;
          end
          MODE_START: begin
            hard_q <= now_q;
            soft_q <= now_q;
          end
          default: hard_q <= hard_q;
        endcase
      end
      if (cmd_i.soft_arm) begin
        soft_delayed_q <= 1'b1;
      end
      if (cmd_i.capture && pass_q && (delta_q > {{(TsW - CfgW){1'b0}}, trace_q}) &&
          (cc_q[kind_q] < CcW'(CAPTURE_DEPTH))) begin
        cc_q[kind_q] <= cc_q[kind_q] + 1'b1;
      end
      if (cmd_i.mem_wr) begin
        mem_vld_q[addr_q] <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q     <= mode_e'(in_user_i);
      now_q      <= in_data_i[TsW-1:0];
      rkind_q    <= in_data_i[InKindBit];
      rslot_q    <= in_data_i[InSlotLsb +: SlotW];
      res_rec_q  <= 1'b0;
      res_slot_q <= '0;
      res_cap_q  <= 1'b0;
      res_kind_q <= 1'b0;
      res_lat_q  <= '0;
      res_ovf_q  <= 1'b0;
      res_cnt_q  <= '0;
    end
    if (cmd_i.delta) begin
      delta_q <= delta_d;
      sh_q    <= delta_d >> 1;
      k_q     <= '0;
      slot_q  <= '0;
      pass_q  <= 1'b0;
      kind_q  <= cmd_i.delta_soft;
      count_q <= !(cmd_i.delta_soft && mode_q == MODE_HRES);
    end
    if (cmd_i.scan) begin
      if (status_o.scan_ge) begin
        slot_q <= SlotW'(k_q);
        if (k_q == '0) begin
          pass_q <= 1'b1;
        end
      end
      sh_q <= sh_q >> 1;
      k_q  <= k_q + 1'b1;
    end
    if (cmd_i.capture && pass_q) begin
      res_slot_q <= slot_q;
      res_rec_q  <= count_q;
      if (delta_q > {{(TsW - CfgW){1'b0}}, trace_q}) begin
        res_kind_q <= kind_q;
        if (cc_q[kind_q] < CcW'(CAPTURE_DEPTH)) begin
          res_cap_q <= 1'b1;
          res_lat_q <= delta_q[LatW-1:0];
        end else begin
          res_ovf_q <= 1'b1;
        end
      end
    end
    if (cmd_i.mem_rd) begin
      rd_q     <= mem[mem_addr];
      rd_vld_q <= mem_vld_q[mem_addr];
      rd_oob_q <= read_oob;
      addr_q   <= mem_addr;
    end
    if (cmd_i.mem_wr) begin
      mem[addr_q] <= rd_eff + 1'b1;
    end
    if (cmd_i.read_out) begin
      res_cnt_q <= rd_oob_q ? '0 : rd_eff;
    end
    if (cmd_i.emit) begin
      out_data_q <= {1'b0, res_cnt_q, res_ovf_q, res_lat_q, res_cap_q, res_slot_q, res_rec_q};
      out_user_q <= res_kind_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

endmodule

@@ hdl/irq_latency_log2_histogram.sv @@
// Sequential block: one item is worked on at a time and the next is taken once its result
// sits in the output register. A start item passes the delta and done states, a slot read
// delta, read and done, and a tick delta, a one-slot-per-cycle scan of the shifted delta
// against the period, eval, optional write and done, scanning twice over on the soft path.
// Reset is asynchronous and active low; it clears stamps, the soft flag, capture counts and
// the valid bit of each histogram counter at once, so no clearing pass is needed.
module irq_latency_log2_histogram
  import ilh_pkg::*;
#(
  parameter int unsigned NUM_SLOTS     = SlotCountDef,
  parameter int unsigned CAPTURE_DEPTH = CaptureDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // timestamp_ns, read_kind, read_slot, zero padding
  input  logic [InTdataW-1:0]  s_axis_tdata,
  // mode
  input  logic [1:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // recorded, slot, capture, capture_latency_ns, capture_overflow, read_count, zero padding
  output logic [OutTdataW-1:0] m_axis_tdata,
  // capture_kind
  output logic                 m_axis_tuser
);

  ilh_cmd_t    cmd;
  ilh_status_t status;

  ilh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ilh_dp #(
    .NUM_SLOTS     (NUM_SLOTS),
    .CAPTURE_DEPTH (CAPTURE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

@@ hdl/ilh_checker.sv @@
module ilh_checker
  import ilh_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata,
  input logic                 m_axis_tuser
);

  a_idle_in_reset: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("Result valid during reset.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("Second item taken while one is in work.");

  a_read_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[OutCntLsb +: CntW] != '0) |->
    (m_axis_tdata[OutOvfBit:0] == '0) && !m_axis_tuser)
    else $error("Slot read result carries tick fields.");

  a_capture_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[OutCapBit] && m_axis_tdata[OutOvfBit]) &&
    (m_axis_tdata[OutCapBit] || (m_axis_tdata[OutLatLsb +: LatW] == '0)))
    else $error("Inconsistent capture fields.");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Stalled result changed.");

endmodule

bind irq_latency_log2_histogram ilh_checker u_ilh_checker (.*);

@@ tb/testbench.sv @@
module testbench
  import ilh_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 64;
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned PhaseItems   = 300;
  localparam int unsigned NumPhases    = 6;

  typedef struct packed {
    logic            recorded;
    logic [SlotW-1:0] slot;
    logic            capture;
    logic            capture_kind;
    logic [LatW-1:0] latency;
    logic            overflow;
    logic [CntW-1:0] read_count;
  } tick_result_t;

  class histogram_tracker;
    logic [TsW-1:0]  period;
    logic [TsW-1:0]  trace;
    logic [TsW-1:0]  hard_stamp;
    logic [TsW-1:0]  soft_stamp;
    bit              soft_delayed;
    logic [CntW-1:0] counts [2][SlotCountDef];
    logic [3:0]      captures [2];
    tick_result_t    pending_results [$];
    int              errors;

    function new();
      period       = TsW'(PeriodReset);
      trace        = TsW'(TraceReset);
      hard_stamp   = '0;
      soft_stamp   = '0;
      soft_delayed = 1'b0;
      errors       = 0;
      captures     = '{default: '0};
      for (int k = 0; k < 2; k++) begin
        for (int s = 0; s < SlotCountDef; s++) begin
          counts[k][s] = '0;
        end
      end
    endfunction

    function void set_reg(reg_idx_e idx, logic [CfgW-1:0] value);
      if (idx == REG_PERIOD) begin
        period = TsW'(value);
      end else begin
        trace = TsW'(value);
      end
    endfunction

    function logic [SlotW-1:0] log2_slot(logic [TsW-1:0] delta);
      logic [SlotW-1:0] s = '0;
      for (int k = 0; k < SlotCountDef; k++) begin
        if ((delta >> (k + 1)) >= period) begin
          s = SlotW'(k);
        end
      end
      return s;
    endfunction

    function bit weigh_delta(logic [TsW-1:0] delta, bit kind, bit count,
                             inout tick_result_t r);
      logic [SlotW-1:0] s;
      if ((delta >> 1) < period) begin
        return 1'b0;
      end
      s = log2_slot(delta);
      r.slot = s;
      if (count) begin
        counts[kind][s] = counts[kind][s] + 1;
        r.recorded = 1'b1;
      end
      if (delta > trace) begin
        r.capture_kind = kind;
        if (captures[kind] < CaptureDepthDef) begin
          captures[kind] = captures[kind] + 4'd1;
          r.capture = 1'b1;
          r.latency = delta[LatW-1:0];
        end else begin
          r.overflow = 1'b1;
        end
      end
      return 1'b1;
    endfunction

    function void note_item(mode_e mode, logic [TsW-1:0] now, bit kind,
                            logic [SlotW-1:0] rslot);
      tick_result_t r = '0;
      logic [TsW-1:0] delta;
      case (mode)
        MODE_HRES: begin
          delta = now - hard_stamp;
          hard_stamp = now;
          if (!weigh_delta(delta, 1'b0, 1'b1, r) && !soft_delayed) begin
            delta = now - soft_stamp;
            if (delta >= trace + period) begin
              soft_delayed = 1'b1;
              void'(weigh_delta(delta, 1'b1, 1'b0, r));
            end
          end
        end
        MODE_TIMER: begin
          delta = now - soft_stamp;
          soft_stamp = now;
          soft_delayed = 1'b0;
          void'(weigh_delta(delta, 1'b1, 1'b1, r));
        end
        MODE_READ: begin
          if (rslot < SlotCountDef) begin
            r.read_count = counts[kind][rslot];
          end
        end
        default: begin
          hard_stamp = now;
          soft_stamp = now;
        end
      endcase
      pending_results.push_back(r);
    endfunction

    function void compare(string field, logic [TsW-1:0] want, logic [TsW-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OutTdataW-1:0] d, logic kind);
      tick_result_t w;
      if (pending_results.size() == 0) begin
        $error("result arrived with none pending: tdata %0h", d);
        errors++;
        return;
      end
      w = pending_results.pop_front();
      compare("recorded", TsW'(w.recorded), TsW'(d[OutRecBit]));
      compare("slot", TsW'(w.slot), TsW'(d[OutSlotLsb +: SlotW]));
      compare("capture", TsW'(w.capture), TsW'(d[OutCapBit]));
      compare("capture_kind", TsW'(w.capture_kind), TsW'(kind));
      compare("capture_latency_ns", TsW'(w.latency), TsW'(d[OutLatLsb +: LatW]));
      compare("capture_overflow", TsW'(w.overflow), TsW'(d[OutOvfBit]));
      compare("read_count", TsW'(w.read_count), TsW'(d[OutCntLsb +: CntW]));
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic                 cfg_idx_i;
  logic [CfgW-1:0]      cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic [1:0]           s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  histogram_tracker tracker = new();
  int               send_idle_pct = 38;
  int               recv_idle_pct = 51;
  bit               hold_request  = 1'b0;
  int               stall_cycles  = 0;
  logic [TsW-1:0]   now_ns        = '0;
  logic [CfgW-1:0]  phase_period [NumPhases] = '{40'd1000, 40'd1, 40'd0, 40'hFF_FFFF_FFFF,
                                                 40'd37, 40'd12345678};
  logic [CfgW-1:0]  phase_trace  [NumPhases] = '{40'd5000, 40'd1, 40'd1, 40'hFF_FFFF_FFFF,
                                                 40'd12345, 40'd100};

  irq_latency_log2_histogram uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [TsW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [TsW-1:0] tick_step();
    int pick = $urandom_range(0, 99);
    logic [TsW-1:0] p = tracker.period;
    if (pick < 55) begin
      return p + rand64() % (p + 1);
    end else if (pick < 80) begin
      return rand64() >> $urandom_range(0, 63);
    end
    return (p << $urandom_range(1, 21)) + $urandom_range(0, 2) - 1;
  endfunction

  task automatic send(mode_e mode, logic [TsW-1:0] ts, bit kind, logic [SlotW-1:0] rslot);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata                     = '0;
    s_axis_tdata[TsW-1:0]            = ts;
    s_axis_tdata[InKindBit]          = kind;
    s_axis_tdata[InSlotLsb +: SlotW] = rslot;
    s_axis_tuser                     = mode;
    s_axis_tvalid                    = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_item(mode, ts, kind, rslot);
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (tracker.pending_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CfgW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    tracker.set_reg(idx, value);
  endtask

  task automatic random_item();
    int pick = $urandom_range(0, 99);
    if (pick < 5) begin
      send(mode_e'($urandom_range(0, 3)), rand64(), 1'($urandom_range(0, 1)),
           SlotW'($urandom_range(0, 31)));
    end else if (pick < 10) begin
      send(MODE_START, now_ns, 1'($urandom_range(0, 1)), SlotW'($urandom_range(0, 31)));
    end else if (pick < 25) begin
      send(MODE_READ, rand64(), 1'($urandom_range(0, 1)), SlotW'($urandom_range(0, 31)));
    end else if (pick < 45) begin
      now_ns = now_ns + tick_step();
      send(MODE_TIMER, now_ns, 1'($urandom_range(0, 1)), SlotW'($urandom_range(0, 31)));
    end else begin
      now_ns = now_ns + tick_step();
      send(MODE_HRES, now_ns, 1'($urandom_range(0, 1)), SlotW'($urandom_range(0, 31)));
    end
  endtask

  initial begin
    int item_count;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_PERIOD;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_HRES;
    item_count    = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    send(MODE_READ, '0, 1'b0, 5'd0);
    send(MODE_READ, '0, 1'b1, 5'd19);
    send(MODE_READ, '0, 1'b1, 5'd31);
    send(MODE_READ, '1, 1'b0, 5'd20);
    now_ns = 64'd1000;
    send(MODE_START, now_ns, 1'b0, 5'd0);
    now_ns = now_ns + 64'd5_000_000;
    send(MODE_HRES, now_ns, 1'b0, 5'd0);
    now_ns = now_ns + 64'd20_000_000;
    send(MODE_HRES, now_ns, 1'b0, 5'd0);
    now_ns = now_ns + 64'd19_999_999;
    send(MODE_HRES, now_ns, 1'b0, 5'd0);
    now_ns = now_ns + 64'd100_000_000;
    send(MODE_HRES, now_ns, 1'b0, 5'd0);
    now_ns = now_ns + (64'd10_000_000 << 21);
    send(MODE_HRES, now_ns, 1'b0, 5'd0);
    repeat (2) begin
      now_ns = now_ns + 64'd1_000_000;
      send(MODE_HRES, now_ns, 1'b0, 5'd0);
    end
    send(MODE_TIMER, now_ns, 1'b0, 5'd0);
    now_ns = now_ns + 64'd1000;
    send(MODE_TIMER, now_ns, 1'b0, 5'd0);
    send(MODE_READ, '0, 1'b0, 5'd2);
    send(MODE_READ, '0, 1'b1, 5'd19);
    send(MODE_HRES, 64'd5, 1'b0, 5'd0);
    send(MODE_START, '1, 1'b0, 5'd0);
    now_ns = 64'd99_999_999;
    send(MODE_HRES, now_ns, 1'b0, 5'd0);
    repeat (6) begin
      now_ns = now_ns + 64'd1_000_000_000;
      send(MODE_HRES, now_ns, 1'b0, 5'd0);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      write_reg(REG_PERIOD, phase_period[ph]);
      write_reg(REG_TRACE, phase_trace[ph]);
      for (int i = 0; i < PhaseItems; i++) begin
        if (item_count < 600) begin
          send_idle_pct = 38;
          recv_idle_pct = 51;
        end else if (item_count < 1200) begin
          send_idle_pct = 51;
          recv_idle_pct = 38;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        if (ph == 0 && i == 100) begin
          hold_request = 1'b1;
        end
        if (ph == 1 && i == 150) begin
          wait_for_results();
        end
        random_item();
        item_count++;
      end
    end

    drain();
    tracker.errors += tracker.pending_results.size();
    if (tracker.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

@@ irq_latency_log2_histogram.f @@
hdl/ilh_pkg.sv
hdl/ilh_ctrl.sv
hdl/ilh_dp.sv
hdl/irq_latency_log2_histogram.sv
hdl/ilh_checker.sv
tb/testbench.sv
